// ===== rtl/e80d_pkg.sv =====
// e80d_pkg: types and constants for the extended-to-double converter
// no dependencies
package e80d_pkg;
  localparam int unsigned SeW  = 16;
  localparam int unsigned ManW = 64;
  localparam int unsigned DblW = 64;
  localparam logic [14:0] ExtExpMax = 15'h7FFF;
  localparam int ExtBias = 16383;
  localparam int DblBias = 1023;
  localparam int DblExpMax = 2047;
  localparam logic [62:0] DblInfMag = 63'h7FF0000000000000;

  // normalized operand handed from the front stage to the rounding stage
  typedef struct packed {
    logic        sign;
    logic        is_inf;
    logic        is_zero;
    logic signed [16:0] be;
    logic [63:0] norm;
  } norm_t;
endpackage

// ===== rtl/e80d_if.sv =====
// e80d_if: valid/ready channel carrying one word of payload
// depends on nothing; payload width set by parameter
interface e80d_if #(parameter int W = 64) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/e80d_norm.sv =====
// e80d_norm: classification, leading-zero count and exponent rebias
// depends on e80d_pkg
module e80d_norm (
  input  logic [15:0]    se,
  input  logic [63:0]    man,
  output e80d_pkg::norm_t nrm
);
  import e80d_pkg::*;
  logic [6:0] lz;
  logic [63:0] shifted;

  // priority encoder for the leading one
  always_comb begin
    lz = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (man[i]) lz = 7'(63 - i);
    end
  end

  assign shifted = man << lz[5:0];

  always_comb begin
    nrm.sign    = se[15];
    nrm.is_inf  = (se[14:0] == ExtExpMax);
    nrm.is_zero = (man == '0);
    nrm.be      = 17'($signed({2'b0, se[14:0]}) - 17'(ExtBias - DblBias)
                      - $signed({10'b0, lz}));
    nrm.norm    = shifted;
  end
endmodule

// ===== rtl/e80d_round.sv =====
// e80d_round: single nearest-even rounding to binary64, normal or denormal
// depends on e80d_pkg
module e80d_round (
  input  e80d_pkg::norm_t nrm,
  output logic [63:0]     dbl
);
  import e80d_pkg::*;
  logic [7:0]  s;
  logic [63:0] q, rem, half, mask;
  logic        up;
  logic [53:0] qr;
  logic signed [16:0] ber;
  logic        den;

  always_comb begin
    den = (nrm.be < 17'sd1);
    // shift distance: 11 for normals, 12-be for denormals (clamped)
    if (!den) s = 8'd11;
    else if (nrm.be < -17'sd60) s = 8'd72;
    else s = 8'(17'sd12 - nrm.be);
    if (s >= 8'd64) begin
      q = '0;
      mask = '1;
      half = (s == 8'd64) ? 64'h8000000000000000 : 64'h0;
    end else begin
      q = nrm.norm >> s[5:0];
      mask = (64'd1 << s[5:0]) - 64'd1;
      half = 64'd1 << (s[5:0] - 6'd1);
    end
    rem = nrm.norm & mask;
    if (s > 8'd64) up = 1'b0;
    else up = (rem > half) || (rem == half && q[0]);
    qr = q[53:0] + {53'b0, up};
    ber = nrm.be;
    if (!den && qr[53]) begin
      qr = qr >> 1;
      ber = nrm.be + 17'sd1;
    end
    if (nrm.is_inf || (!nrm.is_zero && ber >= 17'(DblExpMax)))
      dbl = {nrm.sign, DblInfMag};
    else if (nrm.is_zero) dbl = {nrm.sign, 63'b0};
    else if (den) dbl = {nrm.sign, 10'b0, qr[52:0]};
    else dbl = {nrm.sign, ber[10:0], qr[51:0]};
  end
endmodule

// ===== rtl/extended80_to_double_unit.sv =====
// extended80_to_double_unit: top level of the extended-to-double converter
// depends on e80d_pkg, e80d_if, e80d_norm, e80d_round
//
// channel | dir | payload
// in_ch   | in  | data[79:64] sign_and_exponent, data[63:0] mantissa
// out_ch  | out | data[63:0] double_bits
//
// one word per cycle while out_ch keeps taking results; input register, then result register
// normalize sits before the input register boundary, rounding after it
// stalls ripple back through ready; each stage holds while its next is full and cannot advance
// reset synchronous, clears the valid bits only
module extended80_to_double_unit (
  input logic    clk,
  input logic    rst_n,
  e80d_if.sink   in_ch,
  e80d_if.source out_ch
);
  import e80d_pkg::*;
  norm_t       nrm_c, nrm_r;
  logic        v1_r, v2_r;
  logic [63:0] dbl_c, dbl_r;
  logic        adv2, adv1;

  e80d_norm u_norm (.se(in_ch.data[79:64]), .man(in_ch.data[63:0]), .nrm(nrm_c));
  e80d_round u_round (.nrm(nrm_r), .dbl(dbl_c));

  assign adv2 = !v2_r || out_ch.ready;
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready  = adv1;
  assign out_ch.valid = v2_r;
  assign out_ch.data  = dbl_r;

  // two-stage pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
    end
    if (adv1 && in_ch.valid) nrm_r <= nrm_c;
    if (adv2 && v1_r) dbl_r <= dbl_c;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result lost under stall");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted word not registered");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !v2_r |=> v2_r)
    else $error("stage one did not advance");
endmodule
